/* hw/rtl/whbt_pkg.sv */
// Shared types, codes and constants of the worker health breaker table.
package whbt_pkg;

    localparam int WORKERS_DEF  = 64;
    localparam int TIME_BITS    = 32;
    localparam int WORKER_BITS  = 6;
    localparam int CFG_BITS     = 31;
    localparam int CFG_IDX_BITS = 2;
    localparam int FAIL_BITS    = 4;
    localparam int QUEUE_DEPTH  = 2;

    // request op codes
    localparam logic [1:0] OP_QUERY = 2'd0;
    localparam logic [1:0] OP_EVENT = 2'd1;
    localparam logic [1:0] OP_RING  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // event kinds
    localparam logic [1:0] EV_SCALE_DOWN = 2'd0;
    localparam logic [1:0] EV_PEER_DEAD  = 2'd1;
    localparam logic [1:0] EV_DISCONNECT = 2'd2;
    localparam logic [1:0] EV_OTHER      = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BURST_WINDOW    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BREAK_LEN       = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EVICT_THRESHOLD = 2'd2;

    localparam logic [CFG_BITS-1:0]  BURST_WINDOW_RST    = 31'd1000;
    localparam logic [CFG_BITS-1:0]  BREAK_LEN_RST       = 31'd5000;
    localparam logic [FAIL_BITS-1:0] EVICT_THRESHOLD_RST = 4'd3;
    localparam logic [FAIL_BITS-1:0] FAIL_MAX            = 4'd15;

    typedef struct packed {
        logic [1:0]             op;
        logic [WORKER_BITS-1:0] worker;
        logic [1:0]             event_kind;
        logic [31:0]            now_time;
    } req_t;

    typedef struct packed {
        logic                 available;
        logic [FAIL_BITS-1:0] failure_count;
    } rsp_t;

    typedef struct packed {
        logic [CFG_BITS-1:0]  burst_window;
        logic [CFG_BITS-1:0]  break_len;
        logic [FAIL_BITS-1:0] evict_threshold;
    } cfg_t;

    // classified command handed from front to back
    typedef enum logic [1:0] {
        CMD_QUERY = 2'd0,
        CMD_EVENT = 2'd1,
        CMD_RING  = 2'd2,
        CMD_OOR   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [WORKER_BITS-1:0] worker;
        logic [1:0]             event_kind;
        logic [TIME_BITS-1:0]   now;
        logic [TIME_BITS-1:0]   end_time;
    } cmd_t;

    // one table entry as stored in the RAM
    typedef struct packed {
        logic [TIME_BITS-1:0] window_start;
        logic [TIME_BITS-1:0] broken_until;
        logic [FAIL_BITS-1:0] fail_count;
        logic                 sticky;
        logic                 timed;
    } entry_t;

endpackage

/* hw/rtl/whbt_ram.sv */
// Generic simple dual-port RAM with registered read.
module whbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/whbt_front.sv */
// Front end: accepts requests, range-checks and classifies them into commands.
module whbt_front #(
    parameter int WORKERS = whbt_pkg::WORKERS_DEF
) (
    input  logic          req_valid,
    output logic          req_stall,
    input  whbt_pkg::req_t req,
    input  whbt_pkg::cfg_t cfg,
    input  logic          q_full,
    input  logic          clearing,
    output logic          push,
    output whbt_pkg::cmd_t cmd
);
    import whbt_pkg::*;

    localparam int CNTW = $clog2(WORKERS + 1);
    localparam int CMPW = (CNTW > WORKER_BITS) ? CNTW : WORKER_BITS;

    logic in_range;

    assign in_range  = CMPW'(req.worker) < CMPW'(WORKERS);
    assign req_stall = q_full || clearing;
    // op 3 is taken and dropped here
    assign push      = req_valid && !req_stall && (req.op != OP_NONE);

    always_comb
    begin
        cmd.worker     = req.worker;
        cmd.event_kind = req.event_kind;
        cmd.now        = TIME_BITS'(req.now_time);
        // end of a break that would start now
        cmd.end_time   = TIME_BITS'(req.now_time) + TIME_BITS'(cfg.break_len);
        unique case (req.op)
            OP_QUERY: cmd.kind = in_range ? CMD_QUERY : CMD_OOR;
            OP_EVENT: cmd.kind = in_range ? CMD_EVENT : CMD_OOR;
            default:  cmd.kind = CMD_RING;
        endcase
    end

endmodule

/* hw/rtl/whbt_queue.sv */
// Short command queue between front and back.
module whbt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  whbt_pkg::cmd_t cmd_in,
    input  logic          pop,
    output whbt_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);
    import whbt_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == NW'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* hw/rtl/whbt_back.sv */
// Back end: entry RAM, read-modify-write sequencer, ring sweep and response register.
module whbt_back #(
    parameter int WORKERS = whbt_pkg::WORKERS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  whbt_pkg::cfg_t cfg,
    input  logic          q_empty,
    input  whbt_pkg::cmd_t q_head,
    output logic          q_pop,
    output logic          clearing,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output whbt_pkg::rsp_t rsp
);
    import whbt_pkg::*;

    localparam int AW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int CW = $clog2(WORKERS + 1);
    localparam int XW = (AW > WORKER_BITS) ? AW : WORKER_BITS;
    localparam int EW = $bits(entry_t);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_RING  = 4'b1000
    } state_t;

    // a strictly before b, wrap-aware
    function automatic logic t_before(input logic [TIME_BITS-1:0] a,
                                      input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS-1:0] d;
        d = a - b;
        return d[TIME_BITS-1];
    endfunction

    state_t        state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic          pend_reg, pend_next;
    cmd_t          cur_reg, cur_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    entry_t               ent, upd, swept;
    logic [XW-1:0]        cur_ext, head_ext;
    logic [TIME_BITS-1:0] gap, neg_ttl;
    logic [FAIL_BITS-1:0] fail_acc;
    logic                 before_now, timed_live, broken, new_burst;
    logic                 started, ttl_before, avail, out_free;

    whbt_ram #(
        .WIDTH (EW),
        .DEPTH (WORKERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent      = entry_t'(ram_rdata);
    assign cur_ext  = XW'(cur_reg.worker);
    assign head_ext = XW'(q_head.worker);
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign clearing = (state_reg == S_CLEAR);

    // a fresh break is already over when the ttl wraps to zero or beyond half range
    assign neg_ttl    = '0 - TIME_BITS'(cfg.break_len);
    assign ttl_before = neg_ttl[TIME_BITS-1];

    // entry update for the command in cur_reg
    always_comb
    begin
        before_now = t_before(cur_reg.now, ent.broken_until);
        timed_live = ent.timed && before_now;
        broken     = ent.sticky || timed_live;
        gap        = cur_reg.now - ent.window_start;
        new_burst  = (ent.fail_count == '0) ||
                     (!gap[TIME_BITS-1] && (gap > TIME_BITS'(cfg.burst_window)));
        if (new_burst)
        begin
            fail_acc = FAIL_BITS'(1);
        end
        else if (ent.fail_count != FAIL_MAX)
        begin
            fail_acc = ent.fail_count + 1'b1;
        end
        else
        begin
            fail_acc = ent.fail_count;
        end

        upd     = ent;
        started = 1'b0;
        if (cur_reg.kind == CMD_EVENT && cur_reg.event_kind != EV_OTHER)
        begin
            // expired timed break is dropped
            upd.timed = timed_live;
            // broken: only scale-down over a timed break goes through
            if (!(broken && (cur_reg.event_kind != EV_SCALE_DOWN || ent.sticky)))
            begin
                unique case (cur_reg.event_kind)
                    EV_SCALE_DOWN:
                    begin
                        upd.sticky     = 1'b1;
                        upd.timed      = 1'b0;
                        upd.fail_count = '0;
                    end
                    EV_PEER_DEAD:
                    begin
                        started = 1'b1;
                    end
                    EV_DISCONNECT:
                    begin
                        upd.fail_count = fail_acc;
                        if (new_burst)
                        begin
                            upd.window_start = cur_reg.now;
                        end
                        if (fail_acc >= cfg.evict_threshold)
                        begin
                            started = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (started)
                begin
                    upd.timed        = 1'b1;
                    upd.sticky       = 1'b0;
                    upd.broken_until = cur_reg.end_time;
                    upd.fail_count   = '0;
                end
            end
        end
        avail = !(upd.sticky || (upd.timed && (started ? ttl_before : before_now)));

        // ring sweep keeps only live timed breaks
        swept = ent;
        if (ent.sticky || !timed_live)
        begin
            swept.timed      = 1'b0;
            swept.sticky     = 1'b0;
            swept.fail_count = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        wr_idx_next    = wr_idx_reg;
        pend_next      = pend_reg;
        cur_next       = cur_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        q_pop          = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = head_ext[AW-1:0];
        ram_we         = 1'b0;
        ram_waddr      = cur_ext[AW-1:0];
        ram_wdata      = EW'(upd);

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = '0;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == CW'(WORKERS - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_head.kind) inside
                        CMD_QUERY, CMD_EVENT:
                        begin
                            q_pop      = 1'b1;
                            ram_re     = 1'b1;
                            cur_next   = q_head;
                            state_next = S_EXEC;
                        end
                        CMD_RING:
                        begin
                            q_pop      = 1'b1;
                            cur_next   = q_head;
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_RING;
                        end
                        default:
                        begin
                            // worker beyond the table
                            if (out_free)
                            begin
                                q_pop                  = 1'b1;
                                rsp_valid_next         = 1'b1;
                                rsp_next.available     = 1'b1;
                                rsp_next.failure_count = '0;
                            end
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    ram_we                 = (cur_reg.kind == CMD_EVENT);
                    rsp_valid_next         = 1'b1;
                    rsp_next.available     = avail;
                    rsp_next.failure_count = upd.fail_count;
                    state_next             = S_IDLE;
                end
            end
            S_RING:
            begin
                // read entry idx while writing back entry idx-1
                ram_re      = (idx_reg != CW'(WORKERS));
                ram_raddr   = idx_reg[AW-1:0];
                ram_we      = pend_reg;
                ram_waddr   = wr_idx_reg;
                ram_wdata   = EW'(swept);
                pend_next   = ram_re;
                wr_idx_next = idx_reg[AW-1:0];
                if (ram_re)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_idx_reg <= wr_idx_next;
        cur_reg    <= cur_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* hw/rtl/worker_health_breaker_table_core.sv */
// Top level of the per-worker circuit breaker health table.
// Per-worker circuit breaker table of WORKERS entries. Requests (query, event,
// ring update) come in on req_valid/req_stall and are classified by the front
// end into a two-deep command queue; the back end runs them against a single
// entry RAM (one write and one registered read port). In the back end a
// query or an event first reads its entry from the RAM, then updates the
// entry, writes it back (events only) and loads the response register once
// that register is free. A query or event for a worker beyond the table
// answers available=1, count=0 without a RAM access. A ring update is
// dispatched, then sweeps every entry with read and write-back overlapped;
// it gives no response. Op 3 is taken and dropped. After reset the back end
// clears every entry of the RAM, with req_stall high while it does so;
// configuration writes are taken at any time (cfg_ready is always high) and
// must only be issued while no transaction is in flight. Responses
// (available, failure_count) leave in request order through a registered
// output that holds while rsp_stall is high, and the front keeps taking
// requests into the queue while a response waits, until the queue is full.
module worker_health_breaker_table_core #(
    parameter int WORKERS = whbt_pkg::WORKERS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    output logic                                   req_stall,
    input  whbt_pkg::req_t                          req,
    output logic                                   rsp_valid,
    input  logic                                   rsp_stall,
    output whbt_pkg::rsp_t                          rsp,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [whbt_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [whbt_pkg::CFG_BITS-1:0]           cfg_wdata
);
    import whbt_pkg::*;

    cfg_t cfg_reg, cfg_next;
    cmd_t cmd, head;
    logic push, pop, q_full, q_empty, clearing;

    // configuration registers; an index beyond the list is dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BURST_WINDOW:    cfg_next.burst_window    = cfg_wdata;
                CFG_BREAK_LEN:       cfg_next.break_len       = cfg_wdata;
                CFG_EVICT_THRESHOLD: cfg_next.evict_threshold = cfg_wdata[FAIL_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.burst_window    <= BURST_WINDOW_RST;
            cfg_reg.break_len       <= BREAK_LEN_RST;
            cfg_reg.evict_threshold <= EVICT_THRESHOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: take and classify the request transaction
    whbt_front #(
        .WORKERS (WORKERS)
    ) u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .clearing  (clearing),
        .push      (push),
        .cmd       (cmd)
    );

    // decouples front and back
    whbt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .cmd_in (cmd),
        .pop    (pop),
        .head   (head),
        .empty  (q_empty),
        .full   (q_full)
    );

    // back: entry RAM read-modify-write, ring sweep, response register
    whbt_back #(
        .WORKERS (WORKERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (head),
        .q_pop     (pop),
        .clearing  (clearing),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

/* hw/rtl/whbt_checker.sv */
// Port-level assertions for the breaker table, bound to the top level.
module whbt_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input whbt_pkg::rsp_t rsp,
    input logic           cfg_valid,
    input logic           cfg_ready
);

    // a stalled response transaction holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // a broken worker never carries a failure count
    a_broken_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.available || (rsp.failure_count == '0))
        else $error("unavailable worker reports nonzero failure count");

    // clearing sweep blocks requests right after reset
    a_clear_stall: assert property (@(posedge clk)
        $rose(rst_n) |-> req_stall)
        else $error("request taken during post-reset clear");

    // config writes never wait
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write not accepted");

endmodule

bind worker_health_breaker_table_core whbt_checker u_whbt_checker (.*);

/* bench/tb_worker_health_breaker_table_core.sv */
// Self-checking bench for the worker health breaker table core.
`timescale 1ns / 1ps

module tb_worker_health_breaker_table_core;
    import whbt_pkg::*;

    localparam int          TABLE_SIZE  = 64;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    // Drain allowance: room for up to three ring sweeps, plus slack.
    localparam int          DRAIN_WAIT  = 250;

    // ------------------------------------------------------------------
    // Breaker state tracker: keeps its own copy of the table and the
    // registers, and predicts the status of every query or event.
    // ------------------------------------------------------------------
    class breaker_tracker;
        logic [CFG_BITS-1:0]  burst_window;
        logic [CFG_BITS-1:0]  break_len;
        logic [FAIL_BITS-1:0] evict_threshold;

        bit                   timed_q  [TABLE_SIZE];
        bit                   sticky_q [TABLE_SIZE];
        logic [31:0]          free_at  [TABLE_SIZE];
        logic [FAIL_BITS-1:0] count_q  [TABLE_SIZE];
        logic [31:0]          window_q [TABLE_SIZE];

        rsp_t pending_status[$];
        int   mismatches;
        bit   failed;

        function new();
            burst_window    = BURST_WINDOW_RST;
            break_len       = BREAK_LEN_RST;
            evict_threshold = EVICT_THRESHOLD_RST;
            for (int w = 0; w < TABLE_SIZE; w++) begin
                timed_q[w]  = 1'b0;
                sticky_q[w] = 1'b0;
                free_at[w]  = '0;
                count_q[w]  = '0;
                window_q[w] = '0;
            end
            mismatches = 0;
            failed     = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
            case (idx)
                CFG_BURST_WINDOW:    burst_window    = val;
                CFG_BREAK_LEN:       break_len       = val;
                CFG_EVICT_THRESHOLD: evict_threshold = val[FAIL_BITS-1:0];
                default: ;
            endcase
        endfunction

        // a strictly earlier than b, wrap-aware
        function bit earlier(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            return d[31];
        endfunction

        function bit down(int w, logic [31:0] t);
            return sticky_q[w] || (timed_q[w] && earlier(t, free_at[w]));
        endfunction

        function void arm_timer(int w, logic [31:0] t);
            timed_q[w]  = 1'b1;
            sticky_q[w] = 1'b0;
            free_at[w]  = t + {1'b0, break_len};
            count_q[w]  = '0;
        endfunction

        function void apply_event(int w, logic [1:0] kind, logic [31:0] t);
            logic [31:0] d;
            if (kind == EV_OTHER)
                return;
            // an expired timed break is dropped so it cannot come back after a wrap
            if (timed_q[w] && !earlier(t, free_at[w]))
                timed_q[w] = 1'b0;
            // broken: ignore, but scale-down still promotes a timed break to sticky
            if (down(w, t) && (kind != EV_SCALE_DOWN || sticky_q[w]))
                return;
            case (kind)
                EV_SCALE_DOWN: begin
                    sticky_q[w] = 1'b1;
                    timed_q[w]  = 1'b0;
                    count_q[w]  = '0;
                end
                EV_PEER_DEAD: arm_timer(w, t);
                default: begin
                    d = t - window_q[w];
                    if (count_q[w] == 0 || (!d[31] && d > {1'b0, burst_window})) begin
                        count_q[w]  = FAIL_BITS'(1);
                        window_q[w] = t;
                    end else if (count_q[w] != FAIL_MAX) begin
                        count_q[w] = count_q[w] + 1'b1;
                    end
                    if (count_q[w] >= evict_threshold)
                        arm_timer(w, t);
                end
            endcase
        endfunction

        // ring update keeps only live timed breaks
        function void ring_sweep(logic [31:0] t);
            for (int w = 0; w < TABLE_SIZE; w++) begin
                if (sticky_q[w] || !timed_q[w] || !earlier(t, free_at[w])) begin
                    timed_q[w]  = 1'b0;
                    sticky_q[w] = 1'b0;
                    count_q[w]  = '0;
                end
            end
        endfunction

        // accepted request transaction
        function void take_request(req_t r);
            rsp_t want;
            case (r.op)
                OP_RING: ring_sweep(r.now_time);
                OP_QUERY, OP_EVENT: begin
                    if (r.op == OP_EVENT)
                        apply_event(r.worker, r.event_kind, r.now_time);
                    want.available     = !down(r.worker, r.now_time);
                    want.failure_count = count_q[r.worker];
                    pending_status.push_back(want);
                end
                default: ;
            endcase
        endfunction

        // accepted response transaction
        function void check_status(rsp_t got);
            rsp_t want;
            if (pending_status.size() == 0) begin
                mismatches++;
                failed = 1'b1;
                if (mismatches <= 10)
                    $display("[%0t] unexpected status: available=%0b count=%0d",
                             $realtime, got.available, got.failure_count);
                return;
            end
            want = pending_status.pop_front();
            if (got.available !== want.available || got.failure_count !== want.failure_count)
            begin
                mismatches++;
                failed = 1'b1;
                if (mismatches <= 10)
                    $display({"[%0t] status mismatch: expected available=%0b count=%0d,",
                              " got available=%0b count=%0d"},
                             $realtime, want.available, want.failure_count,
                             got.available, got.failure_count);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                    clk;
    logic                    rst_n;
    logic                    req_valid;
    logic                    req_stall;
    req_t                    req;
    logic                    rsp_valid;
    logic                    rsp_stall;
    rsp_t                    rsp;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_wdata;

    worker_health_breaker_table_core #(.WORKERS(TABLE_SIZE)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    breaker_tracker sb = new();

    bit          idle_en;      // random idling on both sides
    int          stall_left;
    int unsigned cycles;
    logic [31:0] clock_now;    // running timestamp for random traffic

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Response side: stall comes in random bursts, changed on the falling edge only.
    initial
    begin
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall = 1'b0;
                if (idle_en && rst_n && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 9);
            end
        end
    end

    // Every response transaction is checked on the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_status(rsp);
    end

    function automatic req_t mk(logic [1:0] op, logic [WORKER_BITS-1:0] w,
                                logic [1:0] kind, logic [31:0] t);
        req_t r;
        r.op         = op;
        r.worker     = w;
        r.event_kind = kind;
        r.now_time   = t;
        return r;
    endfunction

    // One request transaction. Valid stays high into the next item unless a
    // gap is drawn; the payload only changes on a falling edge.
    task automatic send_req(input req_t item);
        int gap;
        gap = (idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
        @(negedge clk);
        repeat (gap)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req       = item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.take_request(item);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_regs(input logic [CFG_BITS-1:0] bw, input logic [CFG_BITS-1:0] ttl,
                            input logic [FAIL_BITS-1:0] thr);
        write_reg(CFG_BURST_WINDOW, bw);
        write_reg(CFG_BREAK_LEN, ttl);
        write_reg(CFG_EVICT_THRESHOLD, thr);
    endtask

    // Wait for every predicted status, then let a queued ring sweep finish.
    task automatic drain();
        @(negedge clk);
        req_valid = 1'b0;
        while (sb.pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Next timestamp: mostly small forward steps, some around the break
    // length (expiry edges), a few steps back and a few arbitrary jumps.
    function automatic logic [31:0] next_time();
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(0, 99);
        span = (sb.break_len > 10000) ? 20000 : 2 * sb.break_len;
        if (pick < 60)
            return clock_now + $urandom_range(0, 200);
        else if (pick < 80)
            return clock_now + $urandom_range(0, span);
        else if (pick < 88)
            return clock_now - $urandom_range(1, 100);
        else if (pick < 96)
            return clock_now + {1'b0, sb.break_len} + $urandom_range(0, 2) - 1;
        else
            return $urandom;
    endfunction

    // Step inside a disconnect burst; now and then overrun the window.
    function automatic int unsigned burst_step();
        int unsigned lim;
        if ($urandom_range(0, 9) == 0)
            return sb.burst_window + $urandom_range(1, 50);
        lim = sb.burst_window / 16;
        if (lim > 150)
            lim = 150;
        return $urandom_range(0, lim);
    endfunction

    // Random traffic: mostly disconnect bursts on a few hot workers so that
    // evictions, expiry and re-arming are reached, plus breaks, noise and
    // ring updates. Op 3 is dropped by the block and is not counted.
    task automatic run_phase(input int n_items);
        int                   done;
        int                   pick;
        int                   reps;
        logic [WORKER_BITS-1:0] w;
        logic [1:0]           op;
        logic [1:0]           kind;
        logic [WORKER_BITS-1:0] hot [4];
        hot[0] = $urandom_range(0, 1) ? '1 : '0;
        for (int i = 1; i < 4; i++)
            hot[i] = WORKER_BITS'($urandom_range(0, TABLE_SIZE - 1));
        done = 0;
        while (done < n_items)
        begin
            pick = $urandom_range(0, 99);
            w    = hot[$urandom_range(0, 3)];
            if (pick < 50)
            begin
                reps = (sb.evict_threshold == 0) ? 1 : sb.evict_threshold;
                reps = reps + $urandom_range(0, 2) - 1;
                if (reps < 1)
                    reps = 1;
                repeat (reps)
                begin
                    clock_now = clock_now + burst_step();
                    send_req(mk(OP_EVENT, w, EV_DISCONNECT, clock_now));
                end
                clock_now = next_time();
                send_req(mk(OP_QUERY, w, EV_OTHER, clock_now));
                done += reps + 1;
            end
            else if (pick < 70)
            begin
                kind      = $urandom_range(0, 1) ? EV_PEER_DEAD : EV_SCALE_DOWN;
                clock_now = clock_now + $urandom_range(0, 100);
                send_req(mk(OP_EVENT, w, kind, clock_now));
                clock_now = next_time();
                kind      = 2'($urandom_range(0, 2));
                send_req(mk(OP_EVENT, w, kind, clock_now));
                clock_now = next_time();
                send_req(mk(OP_QUERY, w, EV_OTHER, clock_now));
                done += 3;
            end
            else if (pick < 95)
            begin
                op        = 2'($urandom_range(0, 3));
                kind      = 2'($urandom_range(0, 3));
                clock_now = next_time();
                send_req(mk(op, WORKER_BITS'($urandom_range(0, TABLE_SIZE - 1)), kind,
                            clock_now));
                if (op != OP_NONE)
                    done++;
            end
            else
            begin
                clock_now = next_time();
                send_req(mk(OP_RING, w, EV_OTHER, clock_now));
                done++;
            end
        end
    endtask

    initial
    begin
        // every input known from time zero while reset is held low
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        rsp_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        cycles     = 0;
        idle_en    = 1'b1;
        clock_now  = 32'h0000_2000;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset register values (window 1000, ttl 5000, threshold 3).
        send_req(mk(OP_EVENT, 6'd0,  EV_OTHER,      32'd110));   // ignored kind still answers
        send_req(mk(OP_EVENT, 6'd63, EV_DISCONNECT, 32'd200));
        send_req(mk(OP_EVENT, 6'd63, EV_DISCONNECT, 32'd300));
        send_req(mk(OP_EVENT, 6'd63, EV_DISCONNECT, 32'd400));   // third one evicts
        send_req(mk(OP_QUERY, 6'd63, EV_OTHER,      32'd5399));  // last broken instant
        send_req(mk(OP_QUERY, 6'd63, EV_OTHER,      32'd5400));  // break just over
        send_req(mk(OP_EVENT, 6'd63, EV_DISCONNECT, 32'd5500));  // drops the stale break
        send_req(mk(OP_EVENT, 6'd1,  EV_PEER_DEAD,  32'd5500));
        send_req(mk(OP_EVENT, 6'd1,  EV_SCALE_DOWN, 32'd5600));  // timed becomes sticky
        send_req(mk(OP_QUERY, 6'd1,  EV_OTHER,      32'd20000));
        send_req(mk(OP_EVENT, 6'd2,  EV_SCALE_DOWN, 32'd20000));
        send_req(mk(OP_EVENT, 6'd2,  EV_DISCONNECT, 32'd20010)); // ignored while broken
        send_req(mk(OP_EVENT, 6'd3,  EV_DISCONNECT, 32'd21000));
        send_req(mk(OP_EVENT, 6'd3,  EV_DISCONNECT, 32'd22000)); // exactly on the window edge
        send_req(mk(OP_EVENT, 6'd3,  EV_DISCONNECT, 32'd22500)); // past window, count restarts
        send_req(mk(OP_EVENT, 6'd3,  EV_DISCONNECT, 32'd22400)); // time went back, same burst
        send_req(mk(OP_RING,  6'd0,  EV_OTHER,      32'd22600));
        send_req(mk(OP_QUERY, 6'd1,  EV_OTHER,      32'd22700));
        send_req(mk(OP_QUERY, 6'd3,  EV_OTHER,      32'd22700));
        send_req(mk(OP_NONE,  6'd42, EV_OTHER,      32'd0));     // dropped, no status
        send_req(mk(OP_EVENT, 6'd21, EV_PEER_DEAD,  32'hFFFF_FF00)); // break end wraps
        send_req(mk(OP_QUERY, 6'd21, EV_OTHER,      32'h0000_0010));
        send_req(mk(OP_RING,  6'd21, EV_OTHER,      32'h0000_0020)); // live timed break kept
        send_req(mk(OP_QUERY, 6'd21, EV_OTHER,      32'h0000_1288));
        send_req(mk(OP_EVENT, 6'd42, EV_PEER_DEAD,  32'hFFFF_FFFF));

        run_phase(237);
        drain();

        // small settings: zero window, break length 1, threshold 1
        set_regs('0, 31'd1, 4'd1);
        run_phase(237);
        drain();

        // largest settings
        set_regs('1, '1, FAIL_MAX);
        run_phase(237);
        drain();

        // zero-length break and zero threshold (first disconnect evicts)
        set_regs(31'd200, '0, '0);
        run_phase(237);
        drain();

        set_regs(CFG_BITS'($urandom_range(100, 3000)), CFG_BITS'($urandom_range(200, 8000)),
                 FAIL_BITS'($urandom_range(2, 8)));
        run_phase(237);
        drain();

        // closing stretch at full rate, no idling on either side
        idle_en = 1'b0;
        set_regs(CFG_BITS'($urandom_range(100, 3000)), CFG_BITS'($urandom_range(200, 8000)),
                 FAIL_BITS'($urandom_range(2, 8)));
        clock_now = 32'hFFFF_8000;   // run through the wrap
        run_phase(237);
        drain();

        if (sb.pending_status.size() != 0)
            $display("%0d predicted status transactions never arrived",
                     sb.pending_status.size());
        if (!sb.failed && sb.pending_status.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
